FILE: hw/rtl/gcss_pkg.sv
// Shared constants and types of the glyph cache slot select block.
`default_nettype none
package gcss_pkg;

  localparam int GCSS_SLOTS_DEF = 16;
  localparam int CODE_W         = 16;
  localparam int GWIDTH_W       = 8;
  localparam int SLOT_OUT_W     = 4;
  localparam int STAMP_W        = 32;

  localparam logic [STAMP_W-1:0] STAMP_MAX   = 32'hffff_ffff;
  localparam logic [STAMP_W-1:0] STAMP_RESET = 32'd1;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  hit;
    logic [GWIDTH_W-1:0]   cached_width;
  } gcss_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/glyph_cache_slot_select.sv
// Top level of the glyph cache slot select block: input register, directory, result register.
// Takes one item per cycle while in_stall is low and returns one result per item, via the input and result registers.
// An item waits in the input register; as it moves to the result register the tag compare
// and the first-smallest-stamp tree over all SLOTS entries run as it moves, and a miss
// writes the victim slot at the same edge, so the following item sees the updated directory.
// Replacement is in load order (hits leave stamps alone); all tags start at code 0.
`default_nettype none
module glyph_cache_slot_select
  import gcss_pkg::*;
#(
  parameter int SLOTS = GCSS_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CODE_W-1:0]     in_char_code,
  input  wire logic [GWIDTH_W-1:0]   in_glyph_width,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [SLOT_OUT_W-1:0] out_slot,
  output logic                       out_hit,
  output logic      [GWIDTH_W-1:0]   out_cached_width
);

  logic                s1_valid_r;
  logic [CODE_W-1:0]   s1_code_r;
  logic [GWIDTH_W-1:0] s1_gwidth_r;
  logic                out_valid_r;
  gcss_res_t           out_r;
  gcss_res_t           res;
  logic                s1_go;
  logic                in_take;

  assign s1_go   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take = in_valid && !in_stall;

  gcss_dir #(.SLOTS(SLOTS)) u_dir (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (s1_go),
    .code   (s1_code_r),
    .gwidth (s1_gwidth_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_code_r   <= in_char_code;
      s1_gwidth_r <= in_glyph_width;
    end
    if (s1_go) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot         = out_r.slot;
  assign out_hit          = out_r.hit;
  assign out_cached_width = out_r.cached_width;

endmodule
`default_nettype wire

FILE: hw/rtl/gcss_first_min.sv
// Comparison tree that finds the lowest-numbered entry holding the smallest stamp.
`default_nettype none
module gcss_first_min
  import gcss_pkg::*;
#(
  parameter int SLOTS = GCSS_SLOTS_DEF
) (
  input  wire logic [STAMP_W-1:0]         stamp [SLOTS],
  output logic      [$clog2(SLOTS)-1:0]   idx
);

  localparam int IW = $clog2(SLOTS);
  localparam int P  = 1 << IW;

  logic [STAMP_W-1:0] nv [2*P-1];
  logic [IW-1:0]      ni [2*P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < SLOTS) begin : g_real
      assign nv[P-1+i] = stamp[i];
    end else begin : g_pad
      assign nv[P-1+i] = STAMP_MAX;
    end
    assign ni[P-1+i] = IW'(i);
  end

  for (genvar n = 0; n < P-1; n++) begin : g_node
    logic take_right;
    assign take_right = nv[2*n+2] < nv[2*n+1];
    assign nv[n] = take_right ? nv[2*n+2] : nv[2*n+1];
    assign ni[n] = take_right ? ni[2*n+2] : ni[2*n+1];
  end

  assign idx = ni[0];

endmodule
`default_nettype wire

FILE: hw/rtl/gcss_first_hit.sv
// Priority tree that finds the lowest-numbered matching tag.
`default_nettype none
module gcss_first_hit
  import gcss_pkg::*;
#(
  parameter int SLOTS = GCSS_SLOTS_DEF
) (
  input  wire logic [SLOTS-1:0]         match,
  output logic                          hit,
  output logic      [$clog2(SLOTS)-1:0] idx
);

  localparam int IW = $clog2(SLOTS);
  localparam int P  = 1 << IW;

  logic          nh [2*P-1];
  logic [IW-1:0] ni [2*P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < SLOTS) begin : g_real
      assign nh[P-1+i] = match[i];
    end else begin : g_pad
      assign nh[P-1+i] = 1'b0;
    end
    assign ni[P-1+i] = IW'(i);
  end

  for (genvar n = 0; n < P-1; n++) begin : g_node
    assign nh[n] = nh[2*n+1] | nh[2*n+2];
    assign ni[n] = nh[2*n+1] ? ni[2*n+1] : ni[2*n+2];
  end

  assign hit = nh[0];
  assign idx = ni[0];

endmodule
`default_nettype wire

FILE: hw/rtl/gcss_dir.sv
// Slot directory: tag, stamp and width registers, lookup and replacement.
`default_nettype none
module gcss_dir
  import gcss_pkg::*;
#(
  parameter int SLOTS = GCSS_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire logic [CODE_W-1:0]   code,
  input  wire logic [GWIDTH_W-1:0] gwidth,
  output gcss_res_t                res
);

  localparam int IW = $clog2(SLOTS);

  logic [CODE_W-1:0]   tag_r   [SLOTS];
  logic [STAMP_W-1:0]  stamp_r [SLOTS];
  logic [GWIDTH_W-1:0] width_r [SLOTS];
  logic [STAMP_W-1:0]  cnt_r;

  logic [SLOTS-1:0] match;
  logic             hit;
  logic [IW-1:0]    hit_idx;
  logic [IW-1:0]    victim;
  logic [IW-1:0]    sel;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cmp
    assign match[i] = tag_r[i] == code;
  end

  gcss_first_hit #(.SLOTS(SLOTS)) u_hit (
    .match (match),
    .hit   (hit),
    .idx   (hit_idx)
  );

  gcss_first_min #(.SLOTS(SLOTS)) u_min (
    .stamp (stamp_r),
    .idx   (victim)
  );

  assign sel              = hit ? hit_idx : victim;
  assign res.slot         = SLOT_OUT_W'(sel);
  assign res.hit          = hit;
  assign res.cached_width = hit ? width_r[hit_idx] : gwidth;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_r[i]   <= '0;
        stamp_r[i] <= '0;
        width_r[i] <= '0;
      end
      cnt_r <= STAMP_RESET;
    end else if (go && !hit) begin
      tag_r[victim]   <= code;
      stamp_r[victim] <= cnt_r;
      width_r[victim] <= gwidth;
      cnt_r           <= cnt_r + STAMP_W'(1);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && go && !hit |=> cnt_r == $past(cnt_r) + STAMP_W'(1))
    else $error("stamp counter did not advance on a miss");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !(go && !hit) |=> $stable(cnt_r))
    else $error("stamp counter moved without a miss");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && go && !hit |=> tag_r[$past(victim)] == $past(code))
    else $error("victim slot not loaded with the requested code");

  a_miss_width: assert property (@(posedge clk) disable iff (!rst_n)
    go && !hit |-> res.cached_width == gwidth && res.slot == SLOT_OUT_W'(victim))
    else $error("miss result does not name the victim");
`endif

endmodule
`default_nettype wire
